### rtl/core/six_pulse_thyristor_firing_control_core_macros.svh
// assertion macros shared by the firing control core
`ifndef SIX_PULSE_THYRISTOR_FIRING_CONTROL_CORE_MACROS_SVH
`define SIX_PULSE_THYRISTOR_FIRING_CONTROL_CORE_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define SPTFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define SPTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sptfc_pkg.sv
// shared types, constants and gate table of the firing control core
package sptfc_pkg;

  localparam int unsigned PULSES_PER_PERIOD = 6;
  localparam int unsigned GATE_PULSE_TICKS  = 100;
  localparam int unsigned LOCK_COUNT        = 100;
  localparam int unsigned MISSED_LIMIT      = PULSES_PER_PERIOD * 4;
  localparam int unsigned GOOD_CNT_MAX      = 127;
  localparam int unsigned MISSED_CNT_MAX    = 31;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 80;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SIXTY_DEG   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_MIN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_MAX  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_MAX   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_MIN   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW_MAX    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BRIDGE_EN   = 3'd7;

  typedef enum logic [1:0] {
    MODE_NO_SYNC = 2'd0,
    MODE_RESYNC  = 2'd1,
    MODE_NORMAL  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] sixty_deg_ticks;
    logic [15:0] zero_deg_offset;
    logic [31:0] period_min;
    logic [31:0] period_max;
    logic [15:0] angle_max;
    logic [15:0] alpha_min;
    logic [15:0] slew_max;
    logic [1:0]  bridge_enable;
  } cfg_t;

  // mains sync tracking state
  typedef struct packed {
    mode_t       mode;
    logic [31:0] previous_capture;
    logic [31:0] last_sync_time;
    logic [6:0]  good_period_count;
    logic [4:0]  missed_sync_count;
    logic        sync_seen;
  } sync_state_t;

  function automatic logic [5:0] gate_pair(input logic [2:0] pulse);
    logic [5:0] mask;
    unique case (pulse)
      3'd1:    mask = 6'h21;
      3'd2:    mask = 6'h03;
      3'd3:    mask = 6'h06;
      3'd4:    mask = 6'h0C;
      3'd5:    mask = 6'h18;
      3'd6:    mask = 6'h30;
      default: mask = 6'h00;
    endcase
    return mask;
  endfunction

endpackage

### rtl/core/six_pulse_thyristor_firing_control_core.sv
// top level of the six-pulse thyristor bridge firing control core
//
// channel   | direction | tdata fields (lowest bit up)
// s_axis    | in        | capture_time 32, angle_request 16, fire_time_now 32
// m_axis    | out       | gate_mask 6, main_active 1, forcing_active 1, pulse_number 3,
//           |           | pulse_end_time 32, next_fire_time 32, sync_mode 2, zero fill 3
// cfg       | in        | write enable, register index 3, write data 32
//
// one request per cycle sustained while m_axis takes results; a request goes through
// the input register, then the state update and result register in one step
// rst clears the firing state and loads the register defaults
// a stalled m_axis holds the result and backs up into s_axis after one request
module six_pulse_thyristor_firing_control_core
  import sptfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // capture_time, angle_request, fire_time_now
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // gate_mask, main_active, forcing_active,
                                                // pulse_number, pulse_end_time,
                                                // next_fire_time, sync_mode
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "six_pulse_thyristor_firing_control_core_macros.svh"

  cfg_t        cfg;
  logic        in_valid;
  logic [31:0] in_capture;
  logic [15:0] in_request;
  logic        advance;

  sync_state_t sync_st;
  sync_state_t sync_mid;
  sync_state_t sync_st_next;
  logic [2:0]  pulse_index;
  logic [2:0]  pulse_index_next;
  logic [2:0]  fired;
  logic [15:0] angle_current;
  logic [15:0] angle_current_next;
  logic [31:0] fire_time;
  logic [31:0] fire_time_next;
  logic [31:0] end_time;
  logic [5:0]  gate_mask;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sixty_deg_ticks <= 16'd3333;
      cfg.zero_deg_offset <= 16'd0;
      cfg.period_min      <= 32'd18000;
      cfg.period_max      <= 32'd22000;
      cfg.angle_max       <= 16'd9000;
      cfg.alpha_min       <= 16'd500;
      cfg.slew_max        <= 16'd200;
      cfg.bridge_enable   <= 2'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SIXTY_DEG:   cfg.sixty_deg_ticks <= cfg_wdata[15:0];
        REG_ZERO_OFFSET: cfg.zero_deg_offset <= cfg_wdata[15:0];
        REG_PERIOD_MIN:  cfg.period_min      <= cfg_wdata;
        REG_PERIOD_MAX:  cfg.period_max      <= cfg_wdata;
        REG_ANGLE_MAX:   cfg.angle_max       <= cfg_wdata[15:0];
        REG_ALPHA_MIN:   cfg.alpha_min       <= cfg_wdata[15:0];
        REG_SLEW_MAX:    cfg.slew_max        <= cfg_wdata[15:0];
        default:         cfg.bridge_enable   <= cfg_wdata[1:0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_capture <= s_axis_tdata[31:0];
      in_request <= s_axis_tdata[47:32];
    end
  end

  // pulse advance, cyclic 1..6
  always_comb begin
    priority if (pulse_index >= 3'(PULSES_PER_PERIOD)) begin
      fired = 3'd1;
    end else begin
      fired = pulse_index + 3'd1;
    end
  end

  sptfc_sync u_sync (
    .st           (sync_st),
    .capture_time (in_capture),
    .period_min   (cfg.period_min),
    .period_max   (cfg.period_max),
    .st_next      (sync_mid)
  );

  sptfc_fire u_fire (
    .cfg           (cfg),
    .st            (sync_mid),
    .fired         (fired),
    .angle_current (angle_current),
    .fire_time     (fire_time),
    .angle_request (in_request),
    .st_next       (sync_st_next),
    .angle_next    (angle_current_next),
    .fire_next     (fire_time_next),
    .pulse_next    (pulse_index_next)
  );

  assign end_time  = fire_time + 32'(GATE_PULSE_TICKS);
  assign gate_mask = (cfg.bridge_enable != 2'd0) ? gate_pair(fired) : 6'd0;

  // firing state
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_st.mode              <= MODE_NO_SYNC;
      sync_st.previous_capture  <= '0;
      sync_st.last_sync_time    <= '0;
      sync_st.good_period_count <= '0;
      sync_st.missed_sync_count <= '0;
      sync_st.sync_seen         <= 1'b0;
      pulse_index               <= 3'd1;
      angle_current             <= '0;
      fire_time                 <= '0;
    end else if (advance) begin
      sync_st       <= sync_st_next;
      pulse_index   <= pulse_index_next;
      angle_current <= angle_current_next;
      fire_time     <= fire_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'd0, sync_st_next.mode, fire_time_next, end_time, fired,
                   cfg.bridge_enable[1], cfg.bridge_enable[0], gate_mask};
    end
  end

  `SPTFC_ASSERT_NOW(a_pulse_range, 1'b1, (pulse_index >= 3'd1) && (pulse_index <= 3'd6), "pulse index out of range")
  `SPTFC_ASSERT_NOW(a_no_resync_out, out_valid, out_data[76:75] != MODE_RESYNC, "resync mode reported in result")
  `SPTFC_ASSERT_NEXT(a_stall_hold, out_valid && !m_axis_tready, $stable(pulse_index) && $stable(fire_time), "state moved while result stalled")
  `SPTFC_ASSERT_NOW(a_gate_pair, out_valid, ($countones(out_data[5:0]) == 2) || (out_data[5:0] == 6'd0), "gate mask is not a pair")
  `SPTFC_ASSERT_NOW(a_missed_bound, sync_st.mode == MODE_NORMAL, sync_st.missed_sync_count <= 5'(MISSED_LIMIT), "missed count above limit in normal mode")

endmodule

### rtl/core/sptfc_sync.sv
// mains sync lock tracker: period check, lock and loss counting
module sptfc_sync
  import sptfc_pkg::*;
(
  input  sync_state_t st,
  input  logic [31:0] capture_time,
  input  logic [31:0] period_min,
  input  logic [31:0] period_max,
  output sync_state_t st_next
);

  logic [31:0] dt;
  logic        cap_new;
  logic        period_ok;
  logic [7:0]  good_inc;
  logic [4:0]  missed_inc;

  assign dt        = capture_time - st.previous_capture;
  assign cap_new   = capture_time != st.previous_capture;
  assign period_ok = (dt >= period_min) && (dt <= period_max);
  assign good_inc  = {1'b0, st.good_period_count} + 8'd1;

  always_comb begin
    st_next    = st;
    missed_inc = st.missed_sync_count;
    unique case (st.mode)
      MODE_NO_SYNC: begin
        if (cap_new) begin
          st_next.previous_capture = capture_time;
          if (period_ok) begin
            if (good_inc > 8'(LOCK_COUNT)) begin
              st_next.mode              = MODE_RESYNC;
              st_next.missed_sync_count = '0;
              st_next.last_sync_time    = capture_time;
            end
            st_next.good_period_count = (good_inc > 8'(GOOD_CNT_MAX)) ?
                                        7'(GOOD_CNT_MAX) : good_inc[6:0];
          end else begin
            st_next.good_period_count = '0;
          end
        end
      end
      MODE_NORMAL: begin
        if (cap_new) begin
          st_next.previous_capture = capture_time;
          if (period_ok) begin
            st_next.last_sync_time    = capture_time;
            st_next.missed_sync_count = '0;
            st_next.sync_seen         = 1'b1;
          end else begin
            st_next.good_period_count = '0;
            st_next.mode              = MODE_NO_SYNC;
          end
        end else begin
          if (st.missed_sync_count < 5'(MISSED_CNT_MAX)) begin
            missed_inc = st.missed_sync_count + 5'd1;
          end
          st_next.missed_sync_count = missed_inc;
          if (missed_inc > 5'(MISSED_LIMIT)) begin
            st_next.good_period_count = '0;
            st_next.mode              = MODE_NO_SYNC;
          end
        end
      end
      default: begin
        // resync step does not look at the capture
      end
    endcase
  end

endmodule

### rtl/core/sptfc_fire.sv
// firing angle limiting and next fire time
module sptfc_fire
  import sptfc_pkg::*;
(
  input  cfg_t        cfg,
  input  sync_state_t st,            // sync state after this step's check
  input  logic [2:0]  fired,
  input  logic [15:0] angle_current,
  input  logic [31:0] fire_time,
  input  logic [15:0] angle_request,
  output sync_state_t st_next,
  output logic [15:0] angle_next,
  output logic [31:0] fire_next,
  output logic [2:0]  pulse_next
);

  logic [16:0] x2;
  logic [17:0] x3;
  logic [31:0] ref_time;

  assign x2 = {cfg.sixty_deg_ticks, 1'b0};
  assign x3 = {1'b0, x2} + {2'b00, cfg.sixty_deg_ticks};

  // reference point for the pulse just fired
  always_comb begin
    unique case (fired)
      3'd4:    ref_time = st.last_sync_time - {15'd0, x2};
      3'd5:    ref_time = st.last_sync_time - {16'd0, cfg.sixty_deg_ticks};
      3'd6:    ref_time = st.last_sync_time + {16'd0, cfg.zero_deg_offset};
      3'd1:    ref_time = st.last_sync_time + {16'd0, cfg.sixty_deg_ticks};
      3'd2:    ref_time = st.last_sync_time + {15'd0, x2};
      default: ref_time = st.last_sync_time + {14'd0, x3};
    endcase
  end

  always_comb begin
    logic [15:0] angle_tgt;
    logic [15:0] up;
    logic [15:0] down;
    logic [16:0] delta;
    logic [16:0] sum;
    st_next    = st;
    angle_next = angle_current;
    fire_next  = fire_time;
    pulse_next = fired;
    angle_tgt  = (angle_request > cfg.angle_max) ? cfg.angle_max : angle_request;
    angle_tgt  = (angle_tgt < cfg.alpha_min) ? cfg.alpha_min : angle_tgt;
    up         = angle_tgt - angle_current;
    down       = angle_current - angle_tgt;
    delta      = '0;
    sum        = '0;
    unique case (st.mode)
      MODE_NO_SYNC: begin
        fire_next = fire_time + {16'd0, cfg.sixty_deg_ticks};
      end
      MODE_RESYNC: begin
        st_next.mode = MODE_NORMAL;
        angle_next   = cfg.angle_max;
        fire_next    = st.last_sync_time + {16'd0, cfg.angle_max};
        pulse_next   = 3'(PULSES_PER_PERIOD);
      end
      default: begin
        // slew limited step, delta is signed
        if (angle_tgt >= angle_current) begin
          if (up < cfg.slew_max) begin
            angle_next = angle_tgt;
            delta      = {1'b0, up};
          end else begin
            sum        = {1'b0, angle_current} + {1'b0, cfg.slew_max};
            angle_next = sum[15:0];
            delta      = {1'b0, cfg.slew_max};
          end
        end else begin
          if (down < cfg.slew_max) begin
            angle_next = angle_tgt;
            delta      = 17'd0 - {1'b0, down};
          end else begin
            angle_next = angle_current - cfg.slew_max;
            delta      = 17'd0 - {1'b0, cfg.slew_max};
          end
        end
        if (st.sync_seen) begin
          st_next.sync_seen = 1'b0;
          fire_next         = ref_time + {16'd0, angle_next};
        end else begin
          fire_next = fire_time + {16'd0, cfg.sixty_deg_ticks} + {{15{delta[16]}}, delta};
        end
      end
    endcase
  end

endmodule

### sim/six_pulse_thyristor_firing_control_core_test.sv
// testbench for the six-pulse firing control core: firing requests checked against predicted results
`timescale 1ns / 100ps

module six_pulse_thyristor_firing_control_core_test;
  import sptfc_pkg::*;

  // several times the longest receiver hold-off
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned HOLD_OFF_AT     = 450;
  localparam int unsigned MAX_PRINTED     = 40;

  typedef struct {
    logic [5:0]  gate_mask;
    logic        main_active;
    logic        forcing_active;
    logic [2:0]  pulse_number;
    logic [31:0] pulse_end_time;
    logic [31:0] next_fire_time;
    mode_t       sync_mode;
  } firing_t;

  class firing_tracker;
    cfg_t        cfg;
    logic [2:0]  pulse_index;
    mode_t       mode;
    logic [31:0] prev_capture;
    logic [31:0] last_sync;
    int unsigned good_count;
    int unsigned missed_count;
    bit          sync_seen;
    logic [15:0] angle;
    logic [31:0] fire_time;
    firing_t     expected_firings[$];
    int unsigned requests_seen, results_seen, locks_gained, locks_lost, errors;

    function new();
      cfg = '{16'd3333, 16'd0, 32'd18000, 32'd22000, 16'd9000, 16'd500, 16'd200, 2'd0};
      pulse_index  = 3'd1;
      mode         = MODE_NO_SYNC;
      prev_capture = '0;
      last_sync    = '0;
      good_count   = 0;
      missed_count = 0;
      sync_seen    = 1'b0;
      angle        = '0;
      fire_time    = '0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_SIXTY_DEG:   cfg.sixty_deg_ticks = value[15:0];
        REG_ZERO_OFFSET: cfg.zero_deg_offset = value[15:0];
        REG_PERIOD_MIN:  cfg.period_min      = value;
        REG_PERIOD_MAX:  cfg.period_max      = value;
        REG_ANGLE_MAX:   cfg.angle_max       = value[15:0];
        REG_ALPHA_MIN:   cfg.alpha_min       = value[15:0];
        REG_SLEW_MAX:    cfg.slew_max        = value[15:0];
        REG_BRIDGE_EN:   cfg.bridge_enable   = value[1:0];
        default: ;
      endcase
    endfunction

    function bit in_window(logic [31:0] dt);
      return dt >= cfg.period_min && dt <= cfg.period_max;
    endfunction

    function void drop_lock();
      good_count = 0;
      mode       = MODE_NO_SYNC;
      locks_lost++;
    endfunction

    // advance the firing state by one request and queue the expected result
    function void note_request(logic [31:0] capture, logic [15:0] request);
      firing_t     f;
      logic [2:0]  fired;
      logic [31:0] dt, sixty, slew, target, prev, up, down, delta, anchor, new_angle;
      sixty = {16'd0, cfg.sixty_deg_ticks};
      slew  = {16'd0, cfg.slew_max};
      pulse_index = (pulse_index == 3'd6) ? 3'd1 : pulse_index + 3'd1;
      fired = pulse_index;

      if (mode == MODE_NO_SYNC) begin
        if (capture != prev_capture) begin
          dt = capture - prev_capture;
          prev_capture = capture;
          if (in_window(dt)) begin
            if (good_count + 1 > LOCK_COUNT) begin
              mode         = MODE_RESYNC;
              missed_count = 0;
              last_sync    = capture;
            end
            good_count = (good_count + 1 > GOOD_CNT_MAX) ? GOOD_CNT_MAX : good_count + 1;
          end else begin
            good_count = 0;
          end
        end
      end else if (mode == MODE_NORMAL) begin
        if (capture != prev_capture) begin
          dt = capture - prev_capture;
          prev_capture = capture;
          if (in_window(dt)) begin
            last_sync    = capture;
            missed_count = 0;
            sync_seen    = 1'b1;
          end else begin
            drop_lock();
          end
        end else begin
          if (missed_count < MISSED_CNT_MAX) missed_count++;
          if (missed_count > MISSED_LIMIT) drop_lock();
        end
      end

      f.pulse_end_time = fire_time + GATE_PULSE_TICKS;

      if (mode == MODE_NO_SYNC) begin
        fire_time = fire_time + sixty;
      end else if (mode == MODE_RESYNC) begin
        // lock just gained: restart from the largest angle, next advance fires pulse one
        mode        = MODE_NORMAL;
        angle       = cfg.angle_max;
        fire_time   = last_sync + {16'd0, cfg.angle_max};
        pulse_index = 3'd6;
        locks_gained++;
      end else begin
        // clamp to max first so a min above max wins
        target = {16'd0, request};
        if (target > cfg.angle_max) target = {16'd0, cfg.angle_max};
        if (target < cfg.alpha_min) target = {16'd0, cfg.alpha_min};
        prev = {16'd0, angle};
        if (target >= prev) begin
          up = target - prev;
          if (up < slew) begin
            new_angle = target;
            delta     = up;
          end else if (up > 0) begin
            new_angle = prev + slew;
            delta     = slew;
          end else begin
            new_angle = prev - slew;
            delta     = 32'd0 - slew;
          end
        end else begin
          down = prev - target;
          if (down < slew) begin
            new_angle = target;
            delta     = 32'd0 - down;
          end else begin
            new_angle = prev - slew;
            delta     = 32'd0 - slew;
          end
        end
        angle = new_angle[15:0];
        if (sync_seen) begin
          sync_seen = 1'b0;
          case (pulse_index)
            3'd4:    anchor = last_sync - 2 * sixty;
            3'd5:    anchor = last_sync - sixty;
            3'd6:    anchor = last_sync + {16'd0, cfg.zero_deg_offset};
            3'd1:    anchor = last_sync + sixty;
            3'd2:    anchor = last_sync + 2 * sixty;
            default: anchor = last_sync + 3 * sixty;
          endcase
          fire_time = anchor + {16'd0, angle};
        end else begin
          fire_time = fire_time + sixty + delta;
        end
      end

      if (cfg.bridge_enable == 2'd0) begin
        f.gate_mask = 6'h00;
      end else begin
        case (fired)
          3'd1:    f.gate_mask = 6'h21;
          3'd2:    f.gate_mask = 6'h03;
          3'd3:    f.gate_mask = 6'h06;
          3'd4:    f.gate_mask = 6'h0C;
          3'd5:    f.gate_mask = 6'h18;
          3'd6:    f.gate_mask = 6'h30;
          default: f.gate_mask = 6'h00;
        endcase
      end
      f.main_active    = cfg.bridge_enable[0];
      f.forcing_active = cfg.bridge_enable[1];
      f.pulse_number   = fired;
      f.next_fire_time = fire_time;
      f.sync_mode      = mode;
      expected_firings.push_back(f);
      requests_seen++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_seen, field, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      firing_t want;
      results_seen++;
      if (expected_firings.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = expected_firings.pop_front();
      compare("gate_mask",      32'(d[5:0]),   32'(want.gate_mask));
      compare("main_active",    32'(d[6]),     32'(want.main_active));
      compare("forcing_active", 32'(d[7]),     32'(want.forcing_active));
      compare("pulse_number",   32'(d[10:8]),  32'(want.pulse_number));
      compare("pulse_end_time", d[42:11],      want.pulse_end_time);
      compare("next_fire_time", d[74:43],      want.next_fire_time);
      compare("sync_mode",      32'(d[76:75]), 32'(want.sync_mode));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // capture_time, angle_request, fire_time_now
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // gate_mask, main_active, forcing_active,
                                         // pulse_number, pulse_end_time,
                                         // next_fire_time, sync_mode
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit            calm = 1'b0;
  int unsigned   quiet_cycles = 0;
  int unsigned   settings_used = 1;
  firing_tracker tracker;
  cfg_t          settings[7];

  six_pulse_thyristor_firing_control_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off while requests keep coming
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && tracker.results_seen >= HOLD_OFF_AT) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  task automatic offer(input logic [31:0] capture, input logic [15:0] request,
                       input logic [31:0] spare);
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {spare, request, capture};
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(capture, request);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    tracker.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_SIXTY_DEG,   {16'd0, s.sixty_deg_ticks});
    write_reg(REG_ZERO_OFFSET, {16'd0, s.zero_deg_offset});
    write_reg(REG_PERIOD_MIN,  s.period_min);
    write_reg(REG_PERIOD_MAX,  s.period_max);
    write_reg(REG_ANGLE_MAX,   {16'd0, s.angle_max});
    write_reg(REG_ALPHA_MIN,   {16'd0, s.alpha_min});
    write_reg(REG_SLEW_MAX,    {16'd0, s.slew_max});
    write_reg(REG_BRIDGE_EN,   {30'd0, s.bridge_enable});
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (tracker.expected_firings.size() != 0) @(negedge clk);
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.sixty_deg_ticks = 16'($urandom_range(65535, 1));
    s.zero_deg_offset = 16'($urandom);
    s.period_min      = $urandom_range(32'hFFFF_0000, 1);
    s.period_max      = s.period_min + $urandom_range(5000, 0);
    s.angle_max       = 16'($urandom);
    s.alpha_min       = 16'($urandom);
    s.slew_max        = 16'($urandom_range(2000, 0));
    s.bridge_enable   = 2'($urandom_range(3, 0));
    return s;
  endfunction

  // a sync period inside the accepted window when there is one
  function automatic logic [31:0] sync_period();
    logic [31:0] span;
    if (tracker.cfg.period_min > tracker.cfg.period_max) return $urandom;
    span = tracker.cfg.period_max - tracker.cfg.period_min;
    if (span == 32'hFFFF_FFFF) return $urandom;
    return tracker.cfg.period_min + $urandom_range(span, 0);
  endfunction

  task automatic run_phase(input int unsigned count);
    int unsigned since_edge, spacing, roll;
    logic [31:0] capture;
    logic [15:0] request, lo, hi;
    since_edge = 0;
    spacing    = 6;
    repeat (count) begin
      roll    = $urandom_range(999, 0);
      capture = tracker.prev_capture;
      if (tracker.mode == MODE_NO_SYNC) begin
        // breaks kept rare while unlocked so most runs reach lock
        if (roll < 3) capture = $urandom;
        else if (roll >= 20) capture = tracker.prev_capture + sync_period();
      end else if (roll < 8) begin
        capture = $urandom;
      end else begin
        since_edge++;
        if (since_edge >= spacing) begin
          since_edge = 0;
          roll = $urandom_range(99, 0);
          capture = tracker.prev_capture + ((roll < 2) ? $urandom : sync_period());
          // now and then a run of missed sync edges long enough to lose lock
          spacing = (roll >= 2 && roll < 5) ? 30 : $urandom_range(8, 1);
        end
      end

      lo = (tracker.cfg.alpha_min < tracker.cfg.angle_max) ? tracker.cfg.alpha_min
                                                           : tracker.cfg.angle_max;
      hi = (tracker.cfg.alpha_min < tracker.cfg.angle_max) ? tracker.cfg.angle_max
                                                           : tracker.cfg.alpha_min;
      case ($urandom_range(9, 0))
        0:       request = 16'h0000;
        1:       request = 16'hFFFF;
        2, 3, 4: request = 16'($urandom);
        default: request = 16'($urandom_range(hi, lo));
      endcase
      offer(capture, request, $urandom);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    tracker       = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;

    settings[0] = '{16'd3333, 16'd0, 32'd18000, 32'd22000, 16'd9000, 16'd500, 16'd200, 2'd1};
    settings[1] = '{16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'hFFFF, 2'd3};
    // min above max, zero slew
    settings[2] = '{16'd1, 16'd1234, 32'd100, 32'd150, 16'd300, 16'd2000, 16'd0, 2'd2};
    settings[3] = random_settings();
    settings[4] = random_settings();
    settings[5] = '{16'd4096, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd1, 2'd3};
    // empty period window, lock never comes
    settings[6] = '{16'd2500, 16'd700, 32'd30000, 32'd20000, 16'd4000, 16'd1000, 16'd50, 2'd1};

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed requests under the reset register values
    offer(32'h0000_0000, 16'h0000, 32'h0000_0000);  // capture unchanged while unlocked
    offer(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    offer(32'd19999,     16'd9000, 32'h0000_0000);  // period across the timer wrap
    offer(32'd37999,     16'd500,  32'h0000_0000);  // shortest accepted period
    offer(32'd59999,     16'd499,  32'h0000_0000);  // longest accepted period
    offer(32'd77998,     16'd9001, 32'h0000_0000);  // one tick short
    offer(32'd99999,     16'd1234, 32'h0000_0000);  // one tick long
    offer(32'hAAAA_AAAA, 16'h5555, 32'h5555_5555);
    offer(32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA);
    offer(32'h8000_0000, 16'h8000, 32'h0000_0001);
    offer(32'h7FFF_FFFF, 16'h7FFF, 32'h8000_0000);
    run_phase(184);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      calm <= (p == 2);
      apply_settings(settings[p]);
      run_phase((p == 5) ? 120 : (p == 6) ? 80 : 190);
    end

    wait_drained();
    calm <= 1'b0;
    repeat (8) @(negedge clk);
    $display("%0d firing requests under %0d register settings, %0d results checked",
             tracker.requests_seen, settings_used, tracker.results_seen);
    $display("sync lock gained %0d times and lost %0d times",
             tracker.locks_gained, tracker.locks_lost);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sptfc_pkg.sv
rtl/core/sptfc_sync.sv
rtl/core/sptfc_fire.sv
rtl/core/six_pulse_thyristor_firing_control_core.sv
sim/six_pulse_thyristor_firing_control_core_test.sv
